// ----- hw/rtl/epe_pkg.sv -----
// Shared types and constants of the ECU poll protocol engine.
package epe_pkg;

   localparam int FRAME_BYTES = 32;
   localparam int ADDR_W      = $clog2(FRAME_BYTES);
   localparam int LEN_W       = $clog2(FRAME_BYTES + 1);

   localparam logic [1:0] ACT_INIT = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_BYTE = 2'd2;

   localparam logic [2:0] REQ_NONE   = 3'd0;
   localparam logic [2:0] REQ_WAKEUP = 3'd1;
   localparam logic [2:0] REQ_INIT   = 3'd2;
   localparam logic [2:0] REQ_TBL_11 = 3'd3;
   localparam logic [2:0] REQ_TBL_D1 = 3'd4;

   localparam logic [1:0] FS_NONE = 2'd0;
   localparam logic [1:0] FS_GOOD = 2'd1;
   localparam logic [1:0] FS_BAD  = 2'd2;

   localparam logic [7:0] TYPE_TABLE = 8'h02;
   localparam logic [7:0] SUB_RESET  = 8'h00;
   localparam logic [7:0] SUB_TABLE  = 8'h71;
   localparam logic [7:0] TBL_11     = 8'h11;
   localparam logic [7:0] TBL_D1     = 8'hD1;
   localparam logic [7:0] LEN_MIN    = 8'd3;
   localparam logic [7:0] WD_MAX     = 8'hFF;

   localparam logic [7:0] WD_LIMIT_RST = 8'd10;
   localparam logic [5:0] TICK_DIV_RST = 6'd50;

   localparam logic CSR_WD_LIMIT = 1'b0;
   localparam logic CSR_TICK_DIV = 1'b1;

   typedef enum logic [4:0] {
      PS_NONE   = 5'b00001,
      PS_WAKEUP = 5'b00010,
      PS_INIT   = 5'b00100,
      PS_RUN    = 5'b01000,
      PS_RETRY  = 5'b10000
   } proto_state_type;

   typedef enum logic [2:0] {
      PH_TYPE = 3'b001,
      PH_LEN  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      CS_IDLE = 4'b0001,
      CS_EVAL = 4'b0010,
      CS_EMIT = 4'b0100,
      CS_FWD  = 4'b1000
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] wd_limit;
      logic [5:0] tick_div;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic eval;
      logic emit;
      logic fwd_step;
   } dp_cmd_type;

   typedef struct packed {
      logic fwd;
      logic fwd_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- hw/rtl/epe_csr.sv -----
// Configuration registers of the ECU poll protocol engine.
module epe_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            psel,
   input  logic            penable,
   input  logic            pwrite,
   input  logic [2:0]      paddr,
   input  logic [31:0]     pwdata,
   output logic [31:0]     prdata,
   output logic            pready,
   output epe_pkg::cfg_type cfg
);

   logic [7:0] wd_limit_ff;
   logic [7:0] wd_limit_in;
   logic [5:0] tick_div_ff;
   logic [5:0] tick_div_in;
   logic       wr;

   assign pready = 1'b1;
   assign wr     = psel && penable && pwrite;

   always_comb begin
      wd_limit_in = wd_limit_ff;
      tick_div_in = tick_div_ff;
      if (wr) begin
         unique case (paddr[2])
            epe_pkg::CSR_WD_LIMIT: wd_limit_in = pwdata[7:0];
            epe_pkg::CSR_TICK_DIV: tick_div_in = pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wd_limit_ff <= epe_pkg::WD_LIMIT_RST;
         tick_div_ff <= epe_pkg::TICK_DIV_RST;
      end else begin
         wd_limit_ff <= wd_limit_in;
         tick_div_ff <= tick_div_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         epe_pkg::CSR_WD_LIMIT: prdata = {24'd0, wd_limit_ff};
         epe_pkg::CSR_TICK_DIV: prdata = {26'd0, tick_div_ff};
         default:               prdata = 32'd0;
      endcase
   end

   assign cfg.wd_limit = wd_limit_ff;
   assign cfg.tick_div = tick_div_ff;

endmodule

// ----- hw/rtl/epe_ctrl.sv -----
// Sequencing state machine of the ECU poll protocol engine.
module epe_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  epe_pkg::dp_status_type status,
   output epe_pkg::dp_cmd_type   cmd
);

   epe_pkg::ctrl_state_type state_ff;
   epe_pkg::ctrl_state_type state_in;

   assign req_stall = (state_ff != epe_pkg::CS_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.eval     = 1'b0;
      cmd.emit     = 1'b0;
      cmd.fwd_step = 1'b0;
      unique case (state_ff)
         epe_pkg::CS_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = epe_pkg::CS_EVAL;
            end
         end
         epe_pkg::CS_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.fwd ? epe_pkg::CS_FWD : epe_pkg::CS_EMIT;
         end
         epe_pkg::CS_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = epe_pkg::CS_IDLE;
            end
         end
         epe_pkg::CS_FWD: begin
            if (status.out_free) begin
               cmd.fwd_step = 1'b1;
               if (status.fwd_last) begin
                  state_in = epe_pkg::CS_IDLE;
               end
            end
         end
         default: state_in = epe_pkg::CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= epe_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/epe_datapath.sv -----
// Protocol state, deframer, frame buffer and result register.
module epe_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  epe_pkg::cfg_type       cfg,
   input  epe_pkg::dp_cmd_type    cmd,
   output epe_pkg::dp_status_type status,
   input  logic [1:0]             req_action,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_alive,
   output logic [2:0]             rsp_request,
   output logic [1:0]             rsp_frame_status,
   output logic                   rsp_forward_valid,
   output logic [7:0]             rsp_forward_byte,
   output logic                   rsp_last
);

   localparam int AW = epe_pkg::ADDR_W;
   localparam int LW = epe_pkg::LEN_W;

   logic [1:0] action_ff;
   logic [7:0] byte_ff;

   epe_pkg::proto_state_type pstate_ff, pstate_in;
   epe_pkg::phase_type       phase_ff, phase_in;
   logic [5:0]  tick_ff, tick_in;
   logic [7:0]  wd_ff, wd_in;
   logic [LW-1:0] index_ff, index_in;
   logic [LW-1:0] length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  sub_ff, sub_in;
   logic [7:0]  b3_ff, b3_in;

   logic        res_alive_ff, res_alive_in;
   logic [2:0]  res_req_ff, res_req_in;
   logic [1:0]  res_status_ff, res_status_in;
   logic        fwd;
   logic [AW-1:0] fwd_k_ff, fwd_k_in;
   logic [AW-1:0] fwd_end_ff, fwd_end_in;
   logic        fwd_last;

   logic [7:0]  frame_mem_ff [epe_pkg::FRAME_BYTES];
   logic [7:0]  rdata_ff;
   logic        mem_we;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_alive_ff;
   logic [2:0]  out_req_ff;
   logic [1:0]  out_status_ff;
   logic        out_fv_ff;
   logic [7:0]  out_fb_ff;
   logic        out_last_ff;

   logic [5:0]  tick_next;
   logic [8:0]  wd_next;
   logic [LW-1:0] index_next;
   logic [LW-1:0] len_m1;
   logic [7:0]  sum_next;
   logic [7:0]  sub_eff;
   logic [7:0]  b3_eff;
   logic [1:0]  fs;
   logic        out_free;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign tick_next  = tick_ff + 6'd1;
   assign wd_next    = {1'b0, wd_ff} + 9'd1;
   assign index_next = index_ff + LW'(1);
   assign len_m1     = length_ff - LW'(1);
   assign sum_next   = sum_ff + byte_ff;
   assign sub_eff    = (index_ff == LW'(2)) ? byte_ff : sub_ff;
   assign b3_eff     = (index_ff == LW'(3)) ? byte_ff : b3_ff;
   assign fwd_last   = (fwd_k_ff == fwd_end_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         byte_ff   <= req_rx_byte;
      end
   end

   always_comb begin
      pstate_in     = pstate_ff;
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      wd_in         = wd_ff;
      index_in      = index_ff;
      length_in     = length_ff;
      sum_in        = sum_ff;
      type_in       = type_ff;
      sub_in        = sub_ff;
      b3_in         = b3_ff;
      res_alive_in  = 1'b1;
      res_req_in    = epe_pkg::REQ_NONE;
      res_status_in = epe_pkg::FS_NONE;
      fwd           = 1'b0;
      fwd_end_in    = len_m1[AW-1:0];
      mem_we        = 1'b0;
      fs            = epe_pkg::FS_NONE;
      case (action_ff)
         epe_pkg::ACT_INIT: begin
            pstate_in = epe_pkg::PS_WAKEUP;
            wd_in     = 8'd0;
            tick_in   = 6'd0;
         end
         epe_pkg::ACT_TICK: begin
            if (pstate_ff == epe_pkg::PS_RUN || pstate_ff == epe_pkg::PS_RETRY) begin
               tick_in = (tick_next < cfg.tick_div) ? tick_next : 6'd0;
            end
            if (!((pstate_ff == epe_pkg::PS_RUN || pstate_ff == epe_pkg::PS_RETRY)
                  && (tick_next < cfg.tick_div))) begin
               unique case (pstate_ff)
                  epe_pkg::PS_WAKEUP: begin
                     res_req_in = epe_pkg::REQ_WAKEUP;
                     pstate_in  = epe_pkg::PS_INIT;
                  end
                  epe_pkg::PS_INIT: begin
                     res_req_in = epe_pkg::REQ_INIT;
                     pstate_in  = epe_pkg::PS_RUN;
                  end
                  epe_pkg::PS_RUN: begin
                     res_alive_in = !(wd_next > {1'b0, cfg.wd_limit});
                     wd_in        = wd_next[8] ? epe_pkg::WD_MAX : wd_next[7:0];
                  end
                  epe_pkg::PS_RETRY: begin
                     res_req_in = epe_pkg::REQ_TBL_11;
                     wd_in      = 8'd0;
                     pstate_in  = epe_pkg::PS_RUN;
                  end
                  default: ;
               endcase
            end
         end
         epe_pkg::ACT_BYTE: begin
            if (pstate_ff == epe_pkg::PS_RUN) begin
               unique case (phase_ff)
                  epe_pkg::PH_TYPE: begin
                     mem_we   = 1'b1;
                     type_in  = byte_ff;
                     sum_in   = byte_ff;
                     index_in = index_next;
                     phase_in = epe_pkg::PH_LEN;
                  end
                  epe_pkg::PH_LEN: begin
                     if (byte_ff >= epe_pkg::LEN_MIN &&
                         byte_ff <= 8'(epe_pkg::FRAME_BYTES)) begin
                        mem_we    = 1'b1;
                        length_in = byte_ff[LW-1:0];
                        sum_in    = sum_next;
                        index_in  = index_next;
                        phase_in  = epe_pkg::PH_DATA;
                     end else begin
                        fs        = epe_pkg::FS_BAD;
                        index_in  = '0;
                        length_in = '0;
                        phase_in  = epe_pkg::PH_TYPE;
                     end
                  end
                  epe_pkg::PH_DATA: begin
                     mem_we = 1'b1;
                     sub_in = sub_eff;
                     b3_in  = b3_eff;
                     if (index_next >= length_ff) begin
                        fs        = (sum_next == 8'd0) ? epe_pkg::FS_GOOD : epe_pkg::FS_BAD;
                        index_in  = '0;
                        length_in = '0;
                        phase_in  = epe_pkg::PH_TYPE;
                     end else begin
                        sum_in   = sum_next;
                        index_in = index_next;
                     end
                  end
                  default: ;
               endcase
               res_status_in = fs;
               if (fs == epe_pkg::FS_BAD) begin
                  pstate_in = epe_pkg::PS_RETRY;
               end else if (fs == epe_pkg::FS_GOOD) begin
                  wd_in = 8'd0;
                  if (type_ff == epe_pkg::TYPE_TABLE) begin
                     if (sub_eff == epe_pkg::SUB_RESET) begin
                        res_req_in = epe_pkg::REQ_TBL_11;
                     end else if (sub_eff == epe_pkg::SUB_TABLE) begin
                        fwd = 1'b1;
                        if (b3_eff == epe_pkg::TBL_11) begin
                           res_req_in = epe_pkg::REQ_TBL_D1;
                        end
                        if (b3_eff == epe_pkg::TBL_D1) begin
                           pstate_in = epe_pkg::PS_RETRY;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pstate_ff <= epe_pkg::PS_NONE;
         phase_ff  <= epe_pkg::PH_TYPE;
         tick_ff   <= 6'd0;
         wd_ff     <= 8'd0;
         index_ff  <= '0;
         length_ff <= '0;
      end else if (cmd.eval) begin
         pstate_ff <= pstate_in;
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         wd_ff     <= wd_in;
         index_ff  <= index_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         sum_ff        <= sum_in;
         type_ff       <= type_in;
         sub_ff        <= sub_in;
         b3_ff         <= b3_in;
         res_alive_ff  <= res_alive_in;
         res_req_ff    <= res_req_in;
         res_status_ff <= res_status_in;
         fwd_end_ff    <= fwd_end_in;
      end
   end

   always_comb begin
      fwd_k_in = fwd_k_ff;
      if (cmd.eval) begin
         fwd_k_in = '0;
      end else if (cmd.fwd_step) begin
         fwd_k_in = fwd_k_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      fwd_k_ff <= fwd_k_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.eval && mem_we) begin
         frame_mem_ff[index_ff[AW-1:0]] <= byte_ff;
      end
      rdata_ff <= frame_mem_ff[fwd_k_in];
   end

   assign rsp_valid_in = (cmd.emit || cmd.fwd_step) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_alive_ff  <= res_alive_ff;
         out_req_ff    <= res_req_ff;
         out_status_ff <= res_status_ff;
         out_fv_ff     <= 1'b0;
         out_fb_ff     <= 8'd0;
         out_last_ff   <= 1'b1;
      end else if (cmd.fwd_step) begin
         out_alive_ff  <= 1'b1;
         out_req_ff    <= fwd_last ? res_req_ff : epe_pkg::REQ_NONE;
         out_status_ff <= fwd_last ? res_status_ff : epe_pkg::FS_NONE;
         out_fv_ff     <= 1'b1;
         out_fb_ff     <= rdata_ff;
         out_last_ff   <= fwd_last;
      end
   end

   assign status.fwd      = fwd;
   assign status.fwd_last = fwd_last;
   assign status.out_free = out_free;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_alive         = out_alive_ff;
   assign rsp_request       = out_req_ff;
   assign rsp_frame_status  = out_status_ff;
   assign rsp_forward_valid = out_fv_ff;
   assign rsp_forward_byte  = out_fb_ff;
   assign rsp_last          = out_last_ff;

`ifndef ASSERT_OFF
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == epe_pkg::PH_DATA) |->
      (length_ff >= LW'(3) && length_ff <= LW'(epe_pkg::FRAME_BYTES)))
      else $error("frame length out of range in data phase");

   a_index_bound: assert property (@(posedge clock) disable iff (reset)
      index_ff < LW'(epe_pkg::FRAME_BYTES))
      else $error("frame index past buffer");

   a_fwd_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.fwd_step |-> (fwd_k_ff <= fwd_end_ff))
      else $error("forward count past frame end");

   a_eval_free: assert property (@(posedge clock) disable iff (reset)
      cmd.eval |-> !(cmd.emit || cmd.fwd_step || cmd.load))
      else $error("evaluate overlaps another command");
`endif

endmodule

// ----- hw/rtl/ecu_poll_protocol_engine_unit.sv -----
// Top level of the ECU poll protocol engine.
// Sequencing: a single-result item is accepted in the idle state, evaluated in the evaluate
// state, and its beat is loaded into the output register in the emit state once that is free.
// Flow: a new item is taken only once the last one is done (req_stall is high until then);
// a forwarded frame is read from the frame buffer one beat per cycle while the output is not stalled.
// Reset: synchronous, clears the control and protocol state; the frame buffer is not cleared.
module ecu_poll_protocol_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_action,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_alive,
   output logic [2:0]  rsp_request,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_forward_valid,
   output logic [7:0]  rsp_forward_byte,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   epe_pkg::cfg_type       cfg;
   epe_pkg::dp_cmd_type    cmd;
   epe_pkg::dp_status_type status;

   epe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   epe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   epe_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd               (cmd),
      .status            (status),
      .req_action        (req_action),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_alive         (rsp_alive),
      .rsp_request       (rsp_request),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_forward_valid (rsp_forward_valid),
      .rsp_forward_byte  (rsp_forward_byte),
      .rsp_last          (rsp_last)
   );

endmodule
